// File: design/mpv_pkg.sv
// ----------------------------------------------------------------------------
// mpv_pkg
// Shared types, constants and a SHA-256 round-constant function for the Merkle proof
// verifier.
// ----------------------------------------------------------------------------
package mpv_pkg;

  localparam int HashWords  = 4;
  localparam int WordW      = 64;
  localparam int Rounds     = 64;
  localparam int MsgBits    = 512;

  typedef enum logic [1:0] {
    REQ_LEAF    = 2'd0,
    REQ_SIBLING = 2'd1,
    REQ_ROOT    = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef logic [255:0] digest_t;
  typedef logic [511:0] block_t;

  // Start and first-block controls from the sequencer to the compression core
  typedef struct packed {
    logic start;
    logic first;
  } core_ctl_t;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  localparam digest_t InitH = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                               32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  // Second block of a 64-byte message: 0x80, zeros, bit length
  localparam block_t PadBlock = {32'h80000000, 448'd0, 32'(MsgBits)};

endpackage

// File: design/mpv_sha_core.sv
// ----------------------------------------------------------------------------
// mpv_sha_core
// One SHA-256 compression, one round per cycle, with a 16-word rolling
// message schedule. Chains from the initial value or from its last digest.
// ----------------------------------------------------------------------------
module mpv_sha_core (
  input  logic                clk,
  input  logic                rst_n,
  input  mpv_pkg::core_ctl_t  ctl,
  input  mpv_pkg::block_t     block,
  output logic                done,
  output mpv_pkg::digest_t    digest
);

  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [31:0] w_r [16];
  mpv_pkg::digest_t hv_r;
  logic [5:0] rnd_r;
  logic       busy_r;
  logic       done_r;

  logic [31:0] s0, s1, ch, maj, t1, t2, w15, w2, ws0, ws1, wnew;

  // Round function and schedule extension
  always_comb begin
    s1   = {e_r[5:0], e_r[31:6]} ^ {e_r[10:0], e_r[31:11]} ^ {e_r[24:0], e_r[31:25]};
    ch   = (e_r & f_r) ^ (~e_r & g_r);
    t1   = h_r + s1 + ch + mpv_pkg::round_k(rnd_r) + w_r[0];
    s0   = {a_r[1:0], a_r[31:2]} ^ {a_r[12:0], a_r[31:13]} ^ {a_r[21:0], a_r[31:22]};
    maj  = (a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r);
    t2   = s0 + maj;
    w15  = w_r[1];
    w2   = w_r[14];
    ws0  = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
    ws1  = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
    wnew = w_r[0] + ws0 + w_r[9] + ws1;
  end

  // Load, run 64 rounds, then fold into the chaining value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        if (ctl.first) begin
          hv_r <= mpv_pkg::InitH;
          {a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r} <= mpv_pkg::InitH;
        end else begin
          {a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r} <= hv_r;
        end
        for (int i = 0; i < 16; i++) begin
          w_r[i] <= block[511 - 32*i -: 32];
        end
        rnd_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
        d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
        for (int i = 0; i < 15; i++) begin
          w_r[i] <= w_r[i+1];
        end
        w_r[15] <= wnew;
        rnd_r   <= rnd_r + 6'd1;
        if (rnd_r == 6'(mpv_pkg::Rounds - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          hv_r <= {hv_r[255:224] + (t1 + t2), hv_r[223:192] + a_r,
                   hv_r[191:160] + b_r, hv_r[159:128] + c_r,
                   hv_r[127:96] + d_r + t1, hv_r[95:64] + e_r,
                   hv_r[63:32] + f_r, hv_r[31:0] + g_r};
        end
      end
    end
  end

  assign done   = done_r;
  assign digest = hv_r;

endmodule

// File: design/merkle_proof_verifier.sv
// ----------------------------------------------------------------------------
// merkle_proof_verifier
// Merkle inclusion proof checker over SHA-256, one proof step per transaction.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): req_type 0 loads the leaf hash, 1 hashes
// the running hash with a sibling (order by in_is_left), 2 compares with a
// root and returns one result transaction; type 3 is dropped.
// Output channel (out_valid/out_stall): out_match, held in an output register
// until taken.
// Sequencing: a leaf or dropped item is taken in ST_IDLE. A sibling item runs
// two compressions of 64 rounds on the shared round unit, through ST_RUN1,
// ST_LOAD2 (the load of the padding block) and ST_RUN2. A root item's result
// appears the next cycle.
// in_stall is high while a compression runs, and while a root result waits
// in the output register when another root item arrives. A stalled output
// holds its value. Reset clears the running hash to zero and empties the
// output register.
// ----------------------------------------------------------------------------
module merkle_proof_verifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_hash_w0,
  input  logic [63:0] in_hash_w1,
  input  logic [63:0] in_hash_w2,
  input  logic [63:0] in_hash_w3,
  input  logic        in_is_left,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_match
);

  typedef enum logic [2:0] {ST_IDLE, ST_RUN1, ST_LOAD2, ST_RUN2} state_t;

  state_t state_r;
  mpv_pkg::digest_t run_r;
  logic out_valid_r, out_match_r;
  mpv_pkg::core_ctl_t ctl;
  mpv_pkg::block_t    blk;
  logic               core_done;
  mpv_pkg::digest_t   core_dig;
  mpv_pkg::digest_t   given;
  logic               accept, out_free, root_acc;

  assign given    = {in_hash_w0, in_hash_w1, in_hash_w2, in_hash_w3};
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) ||
                    (in_req_type == mpv_pkg::REQ_ROOT && !out_free);
  assign accept   = in_valid && !in_stall;
  assign root_acc = accept && in_req_type == mpv_pkg::REQ_ROOT;

  // Pick first or padding block
  always_comb begin
    ctl.start = 1'b0;
    ctl.first = 1'b0;
    blk       = mpv_pkg::PadBlock;
    if (state_r == ST_IDLE && accept && in_req_type == mpv_pkg::REQ_SIBLING) begin
      ctl.start = 1'b1;
      ctl.first = 1'b1;
      blk = in_is_left ? {run_r, given} : {given, run_r};
    end else if (state_r == ST_LOAD2) begin
      ctl.start = 1'b1;
    end
  end

  mpv_sha_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .block  (blk),
    .done   (core_done),
    .digest (core_dig)
  );

  // Sequencer, running hash and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      run_r       <= '0;
      out_valid_r <= 1'b0;
      out_match_r <= 1'b0;
    end else begin
      // Load a new result or drop the one just taken
      if (root_acc) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_req_type)
              mpv_pkg::REQ_LEAF:    run_r <= given;
              mpv_pkg::REQ_SIBLING: state_r <= ST_RUN1;
              mpv_pkg::REQ_ROOT:    out_match_r <= (run_r == given);
              default: ;
            endcase
          end
        end
        ST_RUN1:  if (core_done) state_r <= ST_LOAD2;
        ST_LOAD2: state_r <= ST_RUN2;
        ST_RUN2: begin
          if (core_done) begin
            run_r   <= core_dig;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_match = out_match_r;

endmodule

// File: verif/merkle_proof_verifier_test.sv
// ----------------------------------------------------------------------------
// merkle_proof_verifier_test
// Self-checking bench for the Merkle proof verifier: drives leaf, sibling,
// root and unused transactions with random bursts and output stalls, predicts
// each root match with a SHA-256 model of the running hash, and compares.
// ----------------------------------------------------------------------------
module merkle_proof_verifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    mpv_pkg::req_t req;
    logic [63:0]   w [4];
    logic          is_left;
  } proof_step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = '0;
  logic [63:0] in_hash_w0 = '0, in_hash_w1 = '0, in_hash_w2 = '0, in_hash_w3 = '0;
  logic        in_is_left = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_match;

  proof_step_t step_queue [$];
  logic        match_queue [$];
  logic [63:0] tracked_hash [4];
  int          mismatches = 0;
  int          steps_sent = 0;
  int          roots_seen = 0;
  int          matches_seen = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  bit          stim_done = 1'b0;

  merkle_proof_verifier dut (.*);

  always #5 clk = ~clk;

  function automatic logic [31:0] rotr32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One SHA-256 compression over a 16-word block
  function automatic void sha_compress(ref logic [31:0] h [8], input logic [31:0] blk [16]);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++) begin
      s0 = rotr32(w[i-15], 7) ^ rotr32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr32(w[i-2], 17) ^ rotr32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4]; f = h[5]; g = h[6]; hh = h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = hh + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25)) + ((e & f) ^ (~e & g))
           + mpv_pkg::round_k(6'(i)) + w[i];
      t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d;
    h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
  endfunction

  // Hash the 64-byte pair left||right into the tracked hash
  function automatic void hash_node(logic [63:0] lft [4], logic [63:0] rgt [4]);
    logic [31:0] h [8];
    logic [31:0] blk [16];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    for (int i = 0; i < 4; i++) begin
      blk[2*i] = lft[i][63:32];   blk[2*i+1] = lft[i][31:0];
      blk[8+2*i] = rgt[i][63:32]; blk[9+2*i] = rgt[i][31:0];
    end
    sha_compress(h, blk);
    foreach (blk[i]) blk[i] = '0;
    blk[0] = 32'h80000000;
    blk[15] = 32'd512;
    sha_compress(h, blk);
    for (int i = 0; i < 4; i++) tracked_hash[i] = {h[2*i], h[2*i+1]};
  endfunction

  // Advance the tracked proof state by one accepted transaction
  function automatic void apply_step(proof_step_t s);
    logic same;
    case (s.req)
      mpv_pkg::REQ_LEAF: tracked_hash = s.w;
      mpv_pkg::REQ_SIBLING: begin
        if (s.is_left) hash_node(tracked_hash, s.w);
        else hash_node(s.w, tracked_hash);
      end
      mpv_pkg::REQ_ROOT: begin
        same = (tracked_hash == s.w);
        match_queue = {match_queue, same};
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic proof_step_t make_step(mpv_pkg::req_t r, logic [63:0] v [4], logic lft);
    proof_step_t s;
    s.req = r; s.w = v; s.is_left = lft;
    return s;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Driver: bursts of transactions with random gaps
  always @(posedge clk) begin
    proof_step_t s;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        apply_step(step_queue.pop_front());
        steps_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if ((in_valid && !in_stall ? step_queue.size() > 0 : step_queue.size() > 0)
                     && !(in_valid && !in_stall && step_queue.size() == 0)) begin
          s = step_queue[0];
          in_valid <= 1'b1;
          in_req_type <= s.req;
          {in_hash_w0, in_hash_w1, in_hash_w2, in_hash_w3} <= {s.w[0], s.w[1], s.w[2], s.w[3]};
          in_is_left <= s.is_left;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result and keep a stall pattern on the output
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        roots_seen++;
        if (match_queue.size() == 0) report_mismatch("result with none expected");
        else begin
          if (out_match !== match_queue[0])
            report_mismatch($sformatf("match %b, expected %b", out_match, match_queue[0]));
          if (out_match === 1'b1) matches_seen++;
          void'(match_queue.pop_front());
        end
      end
      out_stall <= (($time / 1000) % 4 == 1) ? ($urandom_range(0, 1) == 1) : 1'b0;
    end
  end

  // Queue a proof path from a leaf to its root step; computes the root in tracked_hash, then restores it
  task automatic queue_proof(int depth, bit corrupt);
    logic [63:0] leaf [4], sib [4], root [4];
    logic [63:0] saved [4];
    bit lft;
    proof_step_t path [$];
    foreach (leaf[i]) leaf[i] = rand64();
    path = {path, make_step(mpv_pkg::REQ_LEAF, leaf, $urandom_range(0, 1))};
    saved = tracked_hash;
    tracked_hash = leaf;
    for (int d = 0; d < depth; d++) begin
      foreach (sib[i]) sib[i] = rand64();
      lft = $urandom_range(0, 1);
      path = {path, make_step(mpv_pkg::REQ_SIBLING, sib, lft)};
      if (lft) hash_node(tracked_hash, sib);
      else hash_node(sib, tracked_hash);
    end
    root = tracked_hash;
    tracked_hash = saved;
    if (corrupt) root[$urandom_range(0, 3)][$urandom_range(0, 63)] ^= 1'b1;
    path = {path, make_step(mpv_pkg::REQ_ROOT, root, $urandom_range(0, 1))};
    foreach (path[i]) step_queue = {step_queue, path[i]};
  endtask

  initial begin
    logic [63:0] zeros [4], ones [4], v [4];
    int pick;
    zeros = '{default: '0};
    ones = '{default: '1};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // directed: root and sibling before any leaf, extremes, unused type
    step_queue = {step_queue, make_step(mpv_pkg::REQ_ROOT, zeros, 1'b1)};
    step_queue = {step_queue, make_step(mpv_pkg::REQ_ROOT, ones, 1'b0)};
    step_queue = {step_queue, make_step(mpv_pkg::REQ_SIBLING, zeros, 1'b1)};
    step_queue = {step_queue, make_step(mpv_pkg::REQ_SIBLING, ones, 1'b0)};
    step_queue = {step_queue, make_step(mpv_pkg::REQ_LEAF, ones, 1'b1)};
    step_queue = {step_queue, make_step(mpv_pkg::REQ_ROOT, ones, 1'b1)};
    step_queue = {step_queue, make_step(mpv_pkg::REQ_NONE, zeros, 1'b1)};
    step_queue = {step_queue, make_step(mpv_pkg::REQ_ROOT, ones, 1'b0)};
    step_queue = {step_queue, make_step(mpv_pkg::REQ_LEAF, zeros, 1'b0)};
    step_queue = {step_queue, make_step(mpv_pkg::REQ_ROOT, zeros, 1'b0)};
    step_queue = {step_queue, make_step(mpv_pkg::REQ_ROOT, zeros, 1'b1)};
    queue_proof(1, 1'b0);
    queue_proof(2, 1'b1);
    // random: mostly well-formed proofs, some noise
    while (steps_sent + step_queue.size() < 1000) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) queue_proof($urandom_range(0, 5), $urandom_range(0, 2) == 0);
      else begin
        foreach (v[i]) v[i] = rand64();
        step_queue = {step_queue,
                      make_step(mpv_pkg::req_t'($urandom_range(0, 3)), v,
                                $urandom_range(0, 1))};
      end
      while (step_queue.size() > 20) @(posedge clk);
    end
    while (step_queue.size() > 0 || in_valid) @(posedge clk);
    while (match_queue.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d transactions, %0d root checks (%0d matching)",
             steps_sent, roots_seen, matches_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule
